@@ rtl/core/iim_dataset_stream_parser_core_macros.svh @@
// assertion macros for the iim dataset stream parser
`ifndef IIM_DATASET_STREAM_PARSER_CORE_MACROS_SVH
`define IIM_DATASET_STREAM_PARSER_CORE_MACROS_SVH

// checked at every clock edge outside reset
`define IIMDSP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define IIMDSP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/iimdsp_pkg.sv @@
// types, codes and constants shared by the iim dataset stream parser
package iimdsp_pkg;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MARKER    = 2'd1;
	localparam logic [1:0] ERR_SIZE      = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED = 2'd3;

	localparam logic [7:0]  MARKER_BYTE    = 8'h1C;
	localparam logic [7:0]  EXT_FLAG       = 8'h80;
	localparam logic [15:0] EXT_SIZE_MASK  = 16'h7FFF;
	localparam logic [15:0] MAX_SIZE_BYTES = 16'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  record_number;
		logic [7:0]  dataset_number;
		logic [31:0] payload_length;
		logic [7:0]  payload_byte;
		logic        payload_end;
		logic [1:0]  error_code;
		logic        run_last;
	} result_t;

	function automatic result_t make_result(
		input logic [1:0]  kind,
		input logic [7:0]  rec,
		input logic [7:0]  set,
		input logic [31:0] len,
		input logic [7:0]  pbyte,
		input logic        pend,
		input logic [1:0]  err
	);
		result_t r;
		r.kind           = kind;
		r.record_number  = rec;
		r.dataset_number = set;
		r.payload_length = len;
		r.payload_byte   = pbyte;
		r.payload_end    = pend;
		r.error_code     = err;
		r.run_last       = 1'b0;
		return r;
	endfunction

endpackage

@@ rtl/core/iim_dataset_stream_parser_core.sv @@
// iim dataset stream parser: deframes marker/record/dataset/length datasets from a byte stream
//
// usage
// - byte channel (byte_valid, byte_stall, byte_data): one stream byte per transaction,
//   final_byte set on the last byte of a block
// - result channel (result_valid, result_stall, result_data): dataset headers, payload
//   bytes and one done or error result per block; run_last marks the last result that
//   a byte caused
// - each byte gives zero, one or two results
// - each byte taken is held in the input register, parsed from there, and its results are
//   written into the result queue, which drives the result channel
// - throughput: one byte per cycle while every byte gives at most one result and the
//   result channel is not stalled; a byte that gives two results needs two result transfers
// - the rate is set by the result queue: a byte is parsed only with two free entries
// - byte_stall rises when the input register holds a byte that cannot be parsed yet;
//   a stall on the result channel fills the four-entry queue, then backs up into
//   byte_stall, and no byte or result is ever dropped
// - after an error reported before the end of a block, bytes are swallowed up to and
//   including the final byte
// - reset (arst_n low) empties the queue and the input register and returns the
//   parser to waiting for a dataset marker
`include "iim_dataset_stream_parser_core_macros.svh"

module iim_dataset_stream_parser_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  iimdsp_pkg::byte_in_t  byte_data,
	output logic                  result_valid,
	input  logic                  result_stall,
	output iimdsp_pkg::result_t   result_data
);
	import iimdsp_pkg::*;

	// parser phases
	localparam logic [2:0] PH_MARK  = 3'd0;
	localparam logic [2:0] PH_REC   = 3'd1;
	localparam logic [2:0] PH_SET   = 3'd2;
	localparam logic [2:0] PH_LEN1  = 3'd3;
	localparam logic [2:0] PH_LEN2  = 3'd4;
	localparam logic [2:0] PH_EXT   = 3'd5;
	localparam logic [2:0] PH_DATA  = 3'd6;
	localparam logic [2:0] PH_DRAIN = 3'd7;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// input register
	logic       s1_valid_s1;
	byte_in_t   s1_data_s1;

	// parser state
	logic [2:0]  phase_q, phase_d;
	logic        marker_bad_q, marker_bad_d;
	logic [7:0]  cur_record_q, cur_record_d;
	logic [7:0]  cur_dataset_q, cur_dataset_d;
	logic [7:0]  first_length_byte_q, first_length_byte_d;
	logic [31:0] length_accum_q, length_accum_d;
	logic [2:0]  size_bytes_left_q, size_bytes_left_d;
	logic [31:0] payload_left_q, payload_left_d;

	// result queue storage
	result_t             queue_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	logic        room;
	logic        proc;
	logic        pop;
	logic        a_vld, b_vld;
	result_t     res_a, res_b;
	logic [1:0]  push_n;

	// combinational helpers
	logic [7:0]  in_b;
	logic        in_fin;
	logic [15:0] len2_v;
	logic [15:0] ext_size;
	logic [31:0] accum_next;
	logic [2:0]  size_dec;
	logic [31:0] pay_dec;
	logic        hdr_go;
	logic [31:0] hdr_len;
	logic        fail_go;
	logic [1:0]  fail_code;

	// two free queue entries are needed before a byte is parsed
	assign room       = count_q <= QCNT_W'(QDEPTH - 2);
	assign proc       = s1_valid_s1 & room;
	assign byte_stall = s1_valid_s1 & ~room;

	assign result_valid = count_q != '0;
	assign result_data  = queue_q[rd_ptr_q];
	assign pop          = result_valid & ~result_stall;

	// input register loads whenever the channel is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			s1_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			s1_data_s1 <= byte_data;
		end
	end

	assign in_b       = s1_data_s1.data_byte;
	assign in_fin     = s1_data_s1.final_byte;
	assign len2_v     = {first_length_byte_q, in_b};
	assign ext_size   = len2_v & EXT_SIZE_MASK;
	assign accum_next = {length_accum_q[23:0], in_b};
	assign size_dec   = size_bytes_left_q - 3'd1;
	assign pay_dec    = payload_left_q - 32'd1;

	// parser: next state and up to two results for the byte in the input register
	always_comb begin
		phase_d             = phase_q;
		marker_bad_d        = marker_bad_q;
		cur_record_d        = cur_record_q;
		cur_dataset_d       = cur_dataset_q;
		first_length_byte_d = first_length_byte_q;
		length_accum_d      = length_accum_q;
		size_bytes_left_d   = size_bytes_left_q;
		payload_left_d      = payload_left_q;
		a_vld     = 1'b0;
		b_vld     = 1'b0;
		res_a     = '0;
		res_b     = '0;
		hdr_go    = 1'b0;
		hdr_len   = '0;
		fail_go   = 1'b0;
		fail_code = ERR_NONE;

		if (proc) begin
			unique case (phase_q)
				PH_MARK, PH_REC, PH_SET: begin
					if (phase_q == PH_MARK) begin
						marker_bad_d = in_b != MARKER_BYTE;
						phase_d      = PH_REC;
					end else if (phase_q == PH_REC) begin
						cur_record_d = in_b;
						phase_d      = PH_SET;
					end else begin
						cur_dataset_d = in_b;
						phase_d       = PH_LEN1;
					end
					// short tail is dropped without an error; a done result still ends the block
					if (in_fin) begin
						phase_d = PH_MARK;
						a_vld   = 1'b1;
						res_a   = make_result(KIND_DONE, '0, '0, '0, '0, 1'b0, ERR_NONE);
					end
				end
				PH_LEN1: begin
					if (marker_bad_q) begin
						fail_go   = 1'b1;
						fail_code = ERR_MARKER;
					end else begin
						first_length_byte_d = in_b;
						if (in_fin) begin
							fail_go   = 1'b1;
							fail_code = ERR_TRUNCATED;
						end else begin
							phase_d = PH_LEN2;
						end
					end
				end
				PH_LEN2: begin
					if ((first_length_byte_q & EXT_FLAG) != '0) begin
						if (ext_size > MAX_SIZE_BYTES) begin
							fail_go   = 1'b1;
							fail_code = ERR_SIZE;
						end else begin
							length_accum_d    = '0;
							size_bytes_left_d = ext_size[2:0];
							if (ext_size == '0) begin
								hdr_go  = 1'b1;
								hdr_len = '0;
							end else if (in_fin) begin
								fail_go   = 1'b1;
								fail_code = ERR_TRUNCATED;
							end else begin
								phase_d = PH_EXT;
							end
						end
					end else begin
						hdr_go  = 1'b1;
						hdr_len = {16'd0, len2_v};
					end
				end
				PH_EXT: begin
					length_accum_d    = accum_next;
					size_bytes_left_d = size_dec;
					if (size_dec == '0) begin
						hdr_go  = 1'b1;
						hdr_len = accum_next;
					end else if (in_fin) begin
						fail_go   = 1'b1;
						fail_code = ERR_TRUNCATED;
					end
				end
				PH_DATA: begin
					payload_left_d = pay_dec;
					a_vld = 1'b1;
					res_a = make_result(KIND_PAYLOAD, cur_record_q, cur_dataset_q, '0, in_b,
						pay_dec == '0, ERR_NONE);
					if (pay_dec == '0) begin
						phase_d = PH_MARK;
						if (in_fin) begin
							b_vld = 1'b1;
							res_b = make_result(KIND_DONE, '0, '0, '0, '0, 1'b0, ERR_NONE);
						end
					end else if (in_fin) begin
						phase_d = PH_MARK;
						b_vld   = 1'b1;
						res_b   = make_result(KIND_ERROR, '0, '0, '0, '0, 1'b0, ERR_TRUNCATED);
					end
				end
				PH_DRAIN: begin
					if (in_fin) begin
						phase_d = PH_MARK;
					end
				end
			endcase

			// error result, then drain unless the block already ended
			if (fail_go) begin
				a_vld   = 1'b1;
				res_a   = make_result(KIND_ERROR, '0, '0, '0, '0, 1'b0, fail_code);
				phase_d = in_fin ? PH_MARK : PH_DRAIN;
			end

			// dataset header, then payload, the next dataset, or a truncation error on a final byte
			if (hdr_go) begin
				a_vld = 1'b1;
				res_a = make_result(KIND_HEADER, cur_record_q, cur_dataset_q, hdr_len, '0,
					1'b0, ERR_NONE);
				if (hdr_len == '0) begin
					phase_d = PH_MARK;
					if (in_fin) begin
						b_vld = 1'b1;
						res_b = make_result(KIND_DONE, '0, '0, '0, '0, 1'b0, ERR_NONE);
					end
				end else begin
					payload_left_d = hdr_len;
					if (in_fin) begin
						phase_d = PH_MARK;
						b_vld   = 1'b1;
						res_b   = make_result(KIND_ERROR, '0, '0, '0, '0, 1'b0,
							ERR_TRUNCATED);
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
		end

		res_a.run_last = ~b_vld;
		res_b.run_last = 1'b1;
	end

	assign push_n = {1'b0, a_vld} + {1'b0, b_vld};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q             <= PH_MARK;
			marker_bad_q        <= 1'b0;
			cur_record_q        <= '0;
			cur_dataset_q       <= '0;
			first_length_byte_q <= '0;
			length_accum_q      <= '0;
			size_bytes_left_q   <= '0;
			payload_left_q      <= '0;
		end else begin
			phase_q             <= phase_d;
			marker_bad_q        <= marker_bad_d;
			cur_record_q        <= cur_record_d;
			cur_dataset_q       <= cur_dataset_d;
			first_length_byte_q <= first_length_byte_d;
			length_accum_q      <= length_accum_d;
			size_bytes_left_q   <= size_bytes_left_d;
			payload_left_q      <= payload_left_d;
		end
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (a_vld) begin
			queue_q[wr_ptr_q] <= res_a;
		end
		if (b_vld) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res_b;
		end
	end

	`IIMDSP_ASSERT(a_queue_no_overflow, (push_n != 2'd0) |-> (count_q <= QCNT_W'(QDEPTH - 2)), "result queue overflow")
	`IIMDSP_ASSERT(a_data_left_nonzero, (phase_q == PH_DATA) |-> (payload_left_q != '0), "payload phase with no bytes left")
	`IIMDSP_ASSERT(a_ext_size_range, (phase_q == PH_EXT) |-> ((size_bytes_left_q != '0) && (size_bytes_left_q <= 3'd4)), "extended size count out of range")
	`IIMDSP_ASSERT(a_final_restarts, (proc && in_fin) |=> (phase_q == PH_MARK), "final byte did not restart the parser")
	`IIMDSP_ASSERT(a_count_bound, count_q <= QCNT_W'(QDEPTH), "result queue count beyond depth")
	`IIMDSP_ASSERT_ALWAYS(a_reset_empties, !arst_n |=> (count_q == '0), "queue not empty in reset")

endmodule

@@ tb/sv/iim_dataset_stream_parser_core_checker.sv @@
// dataset parser checker: predicts results from accepted bytes and compares them in order
module iim_dataset_stream_parser_core_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic                 byte_stall,
	input  iimdsp_pkg::byte_in_t byte_data,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  iimdsp_pkg::result_t  result_data,
	output int                   mismatches,
	output int                   outstanding
);
	import iimdsp_pkg::*;

	typedef enum logic [2:0] {
		PH_MARKER, PH_RECORD, PH_DATASET, PH_LEN_HI, PH_LEN_LO, PH_EXT_SIZE, PH_PAYLOAD,
		PH_DRAIN
	} parse_phase_t;

	parse_phase_t phase;
	logic         marker_bad;
	logic [7:0]   cur_record;
	logic [7:0]   cur_dataset;
	logic [7:0]   len_hi;
	logic [31:0]  len_accum;
	logic [2:0]   size_left;
	logic [31:0]  payload_left;

	result_t step_results[$];
	result_t expected_results[$];

	function automatic void add_result(logic [1:0] kind, logic [7:0] rec, logic [7:0] set,
			logic [31:0] len, logic [7:0] pbyte, logic pend, logic [1:0] err);
		result_t r;
		if (step_results.size() >= 2)
			return;
		r.kind           = kind;
		r.record_number  = rec;
		r.dataset_number = set;
		r.payload_length = len;
		r.payload_byte   = pbyte;
		r.payload_end    = pend;
		r.error_code     = err;
		r.run_last       = 1'b0;
		step_results = {step_results, r};
	endfunction

	function automatic void raise_error(logic [1:0] err, logic fin);
		add_result(KIND_ERROR, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, err);
		phase = fin ? PH_MARKER : PH_DRAIN;
	endfunction

	function automatic void emit_header(logic [31:0] len, logic fin);
		add_result(KIND_HEADER, cur_record, cur_dataset, len, 8'd0, 1'b0, ERR_NONE);
		if (len == 32'd0) begin
			phase = PH_MARKER;
			if (fin)
				add_result(KIND_DONE, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, ERR_NONE);
		end else begin
			payload_left = len;
			if (fin)
				raise_error(ERR_TRUNCATED, 1'b1);
			else
				phase = PH_PAYLOAD;
		end
	endfunction

	function automatic void parse_byte(byte_in_t item);
		logic [7:0]  b;
		logic        fin;
		logic [15:0] v;
		b   = item.data_byte;
		fin = item.final_byte;
		step_results.delete();
		case (phase)
			PH_MARKER, PH_RECORD, PH_DATASET: begin
				if (phase == PH_MARKER) begin
					marker_bad = (b != MARKER_BYTE);
					phase      = PH_RECORD;
				end else if (phase == PH_RECORD) begin
					cur_record = b;
					phase      = PH_DATASET;
				end else begin
					cur_dataset = b;
					phase       = PH_LEN_HI;
				end
				// a short tail is dropped without an error; a done result still ends the block
				if (fin) begin
					phase = PH_MARKER;
					add_result(KIND_DONE, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, ERR_NONE);
				end
			end
			PH_LEN_HI: begin
				if (marker_bad)
					raise_error(ERR_MARKER, fin);
				else begin
					len_hi = b;
					if (fin)
						raise_error(ERR_TRUNCATED, 1'b1);
					else
						phase = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				v = {len_hi, b};
				if ((len_hi & EXT_FLAG) != 8'd0) begin
					v = v & EXT_SIZE_MASK;
					if (v > MAX_SIZE_BYTES)
						raise_error(ERR_SIZE, fin);
					else begin
						len_accum = 32'd0;
						size_left = v[2:0];
						if (v == 16'd0)
							emit_header(32'd0, fin);
						else if (fin)
							raise_error(ERR_TRUNCATED, 1'b1);
						else
							phase = PH_EXT_SIZE;
					end
				end else
					emit_header({16'd0, v}, fin);
			end
			PH_EXT_SIZE: begin
				len_accum = {len_accum[23:0], b};
				size_left = size_left - 3'd1;
				if (size_left == 3'd0)
					emit_header(len_accum, fin);
				else if (fin)
					raise_error(ERR_TRUNCATED, 1'b1);
			end
			PH_PAYLOAD: begin
				payload_left = payload_left - 32'd1;
				add_result(KIND_PAYLOAD, cur_record, cur_dataset, 32'd0, b,
					payload_left == 32'd0, ERR_NONE);
				if (payload_left == 32'd0) begin
					phase = PH_MARKER;
					if (fin)
						add_result(KIND_DONE, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, ERR_NONE);
				end else if (fin)
					raise_error(ERR_TRUNCATED, 1'b1);
			end
			default: begin
				if (fin)
					phase = PH_MARKER;
			end
		endcase
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].run_last = 1'b1;
		foreach (step_results[i])
			expected_results = {expected_results, step_results[i]};
	endfunction

	function automatic string describe(result_t r);
		return $sformatf("kind %0d rec %h set %h len %h byte %h end %0d err %0d last %0d",
			r.kind, r.record_number, r.dataset_number, r.payload_length, r.payload_byte,
			r.payload_end, r.error_code, r.run_last);
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: %s", describe(got));
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		if (got !== want) begin
			if (mismatches < 10)
				$display("result mismatch: expected %s, got %s", describe(want), describe(got));
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase        = PH_MARKER;
			marker_bad   = 1'b0;
			cur_record   = 8'd0;
			cur_dataset  = 8'd0;
			len_hi       = 8'd0;
			len_accum    = 32'd0;
			size_left    = 3'd0;
			payload_left = 32'd0;
			expected_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (byte_valid && !byte_stall)
				parse_byte(byte_data);
			if (result_valid && !result_stall)
				check_result(result_data);
			outstanding <= expected_results.size();
		end
	end

endmodule

@@ tb/sv/iim_dataset_stream_parser_core_tb.sv @@
// testbench top for the iim dataset stream parser: stimulus, stall pattern and verdict
module iim_dataset_stream_parser_core_tb;
	import iimdsp_pkg::*;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     byte_valid   = 1'b0;
	logic     byte_stall;
	byte_in_t byte_data    = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	result_t  result_data;

	int mismatches;
	int outstanding;

	// bytes of the block being built, final flag goes on the last one
	logic [7:0] block_q[$];
	int         bytes_sent = 0;

	// result side stall pattern
	int stall_left  = 0;
	bit stall_quiet = 1'b0;

	iim_dataset_stream_parser_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	iim_dataset_stream_parser_core_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result stall: mostly short bursts, now and then a long one, with quiet stretches
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (!stall_quiet && $urandom_range(0, 99) < 25) begin
			result_stall <= 1'b1;
			stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
			                                            : $urandom_range(0, 2);
		end else
			result_stall <= 1'b0;
		if ($urandom_range(0, 499) == 0)
			stall_quiet <= !stall_quiet;
	end

	// idle gap before a byte: none in burst mode, else mostly short and a few long
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// one byte transaction; called and returning just after a rising edge
	task automatic send_byte(byte_in_t item, bit burst);
		int gap;
		gap = pick_gap(burst);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= item;
		// the byte holds until an edge with stall low takes it
		do
			@(posedge clk);
		while (byte_stall);
		bytes_sent++;
	endtask

	task automatic send_block(bit burst);
		byte_in_t item;
		foreach (block_q[i]) begin
			item.data_byte  = block_q[i];
			item.final_byte = (i == block_q.size() - 1);
			send_byte(item, burst);
		end
		block_q.delete();
	endtask

	function automatic void add_byte(logic [7:0] b);
		block_q = {block_q, b};
	endfunction

	function automatic void push_random(int count);
		repeat (count) add_byte(8'($urandom_range(0, 255)));
	endfunction

	// well-formed dataset with a short payload, plain or extended length
	function automatic void add_good_dataset();
		int plen;
		int nsize;
		plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
		add_byte(MARKER_BYTE);
		push_random(2);
		if ($urandom_range(0, 99) < 60) begin
			add_byte(8'h00);
			add_byte(plen[7:0]);
		end else begin
			// extended form: size field 0..4, value in its last byte
			nsize = $urandom_range(0, 4);
			if (nsize == 0)
				plen = 0;
			add_byte(EXT_FLAG);
			add_byte(nsize[7:0]);
			for (int i = 0; i < nsize; i++)
				add_byte((i == nsize - 1) ? plen[7:0] : 8'h00);
		end
		push_random(plen);
	endfunction

	// dataset with a nonzero declared length, cut off anywhere from the first length byte on
	function automatic void add_truncated_dataset();
		logic [7:0] ds[$];
		int         nsize;
		int         cut;
		ds = {ds, MARKER_BYTE};
		ds = {ds, 8'($urandom_range(0, 255))};
		ds = {ds, 8'($urandom_range(0, 255))};
		if ($urandom_range(0, 1) == 0) begin
			ds = {ds, 8'($urandom_range(0, 127))};
			ds = {ds, 8'($urandom_range(1, 255))};
		end else begin
			nsize = $urandom_range(1, 4);
			ds = {ds, EXT_FLAG};
			ds = {ds, nsize[7:0]};
			for (int i = 0; i < nsize; i++)
				ds = {ds, (i == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255))};
		end
		repeat ($urandom_range(0, 5)) ds = {ds, 8'($urandom_range(0, 255))};
		cut = $urandom_range(4, ds.size());
		for (int i = 0; i < cut; i++)
			add_byte(ds[i]);
	endfunction

	// extended length whose size field is above four
	function automatic void add_oversize_dataset();
		logic [7:0] hi;
		add_byte(MARKER_BYTE);
		push_random(2);
		hi = EXT_FLAG | 8'($urandom_range(0, 127));
		add_byte(hi);
		add_byte((hi == EXT_FLAG) ? 8'($urandom_range(5, 255)) : 8'($urandom_range(0, 255)));
		push_random($urandom_range(0, 5));
	endfunction

	// wrong marker, caught at the first length byte
	function automatic void add_bad_marker_dataset();
		logic [7:0] mark;
		mark = 8'($urandom_range(0, 255));
		if (mark == MARKER_BYTE)
			mark = ~mark;
		add_byte(mark);
		push_random(3);
		push_random($urandom_range(0, 5));
	endfunction

	initial begin
		int kind_pick;
		bit burst;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: dataset ending on the final byte, payload end and done together
		block_q = '{MARKER_BYTE, 8'h02, 8'h05, 8'h00, 8'h02, 8'hAA, 8'hFF};
		send_block(1'b1);
		// zero length header ending the block
		block_q = '{MARKER_BYTE, 8'h01, 8'h00, 8'h00, 8'h00};
		send_block(1'b0);
		// one-byte short tail
		block_q = '{8'h00};
		send_block(1'b1);
		// bad marker before the end of the block, then drained
		block_q = '{8'h1D, 8'h02, 8'h03, 8'h00, 8'h01};
		send_block(1'b0);
		// four-byte extended length of all ones, truncated in the payload
		block_q = '{MARKER_BYTE, 8'hFF, 8'hFF, 8'h80, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55};
		send_block(1'b1);

		// random blocks: mostly well-formed, the rest broken in every way the parser reports
		while (bytes_sent < 800) begin
			burst     = ($urandom_range(0, 9) < 3);
			kind_pick = $urandom_range(0, 99);
			if (kind_pick < 55) begin
				repeat ($urandom_range(1, 3)) add_good_dataset();
				// sometimes end on a short tail instead of a dataset boundary
				if ($urandom_range(0, 3) == 0)
					push_random($urandom_range(1, 3));
			end else if (kind_pick < 90) begin
				repeat ($urandom_range(0, 2)) add_good_dataset();
				if (kind_pick < 70)
					add_truncated_dataset();
				else if (kind_pick < 80)
					add_oversize_dataset();
				else
					add_bad_marker_dataset();
			end else
				push_random($urandom_range(1, 12));
			send_block(burst);
		end
		byte_valid <= 1'b0;

		// let the count of the last transaction settle, drain, then watch for stray results
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("iim_dataset_stream_parser_core test passed");
		else
			$display("iim_dataset_stream_parser_core test failed");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#5000000;
		$display("iim_dataset_stream_parser_core test failed");
		$finish;
	end

endmodule
